// ===== src/cpe_pkg.sv =====
package cpe_pkg;

    localparam int CORDIC_STEPS = 32;

    // Magnitudes are normalized so that the larger one has its top bit at NORM_W-1
    localparam int NORM_W = 41;
    // Vectoring datapath: normalized magnitude times CORDIC gain, plus sign
    localparam int VEC_W  = 45;
    localparam int VECZ_W = 34;
    // Rotation datapath: 1/gain at a scale of 2^30, plus sign and headroom
    localparam int ROT_W  = 33;
    localparam int ROTZ_W = 33;

    localparam logic [32:0] QUARTER_TURN = 33'h0_4000_0000;
    localparam logic [32:0] HALF_TURN    = 33'h0_8000_0000;
    localparam logic [32:0] THREE_QUARTER_TURN = 33'h0_C000_0000;
    localparam logic [32:0] FULL_TURN    = 33'h1_0000_0000;

    localparam logic signed [ROT_W-1:0] INV_GAIN = 33'sd652032874;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

endpackage

// ===== src/complex_phase_extractor_core.sv =====
// Channel   | Ports                                   | Transfer
// ----------+-----------------------------------------+------------------------------
// sample in | i_real_part, i_imag_part                | i_start high, o_busy low
// result    | o_phase_turns, o_cos_value, o_sin_value | o_valid high for one cycle
//
// Fully pipelined CORDIC: one sample per cycle while o_busy is low. From transfer
// to o_valid a sample passes 1 input, 6 normalize, 32 vectoring, 1 quadrant,
// 32 rotation, 1 output map and 1 round/saturate stage.
// o_busy is high only during reset and the cycle after; afterwards it stays low.
// The result side cannot stall, so nothing is ever held back inside the pipe.
module complex_phase_extractor_core #(
    parameter int DATA_WIDTH  = 24,
    parameter int PHASE_WIDTH = 16,
    parameter int TRIG_WIDTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [DATA_WIDTH-1:0]  i_real_part,
    input  logic signed [DATA_WIDTH-1:0]  i_imag_part,
    output logic                          o_valid,
    output logic        [PHASE_WIDTH-1:0] o_phase_turns,
    output logic signed [TRIG_WIDTH-1:0]  o_cos_value,
    output logic signed [TRIG_WIDTH-1:0]  o_sin_value
);

    localparam int NSTEPS   = cpe_pkg::CORDIC_STEPS;
    localparam int NORM_N   = 6;
    localparam int VEC_BASE = 1 + NORM_N;          // first vectoring stage
    localparam int ANG_STG  = VEC_BASE + NSTEPS;   // quadrant stage
    localparam int STAGES   = ANG_STG + NSTEPS + 3;
    localparam int TRIG_SH  = 31 - TRIG_WIDTH;
    localparam logic signed [33:0] TRIG_MAX = (34'sd1 <<< (TRIG_WIDTH - 1)) - 34'sd1;
    localparam logic signed [33:0] TRIG_MIN = -TRIG_MAX - 34'sd1;
    localparam logic signed [33:0] TRIG_RND = 34'sd1 <<< (TRIG_SH - 1);

    typedef struct packed {
        logic re_zero;
        logic re_neg;
        logic im_zero;
        logic im_neg;
    } t_flags;

    logic in_xfer;
    logic r_busy;
    logic [STAGES-1:0] r_vld;

    assign in_xfer = i_start && !r_busy;
    assign o_busy  = r_busy;
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[STAGES-2:0], in_xfer};
        end
    end

    // ---------------- input stage: magnitudes and sign flags ----------------
    logic [DATA_WIDTH-1:0] re_mag, im_mag;
    t_flags                n_flag_in;

    assign re_mag = i_real_part[DATA_WIDTH-1] ? DATA_WIDTH'(-i_real_part)
                                              : DATA_WIDTH'(i_real_part);
    assign im_mag = i_imag_part[DATA_WIDTH-1] ? DATA_WIDTH'(-i_imag_part)
                                              : DATA_WIDTH'(i_imag_part);
    assign n_flag_in.re_zero = (i_real_part == '0);
    assign n_flag_in.re_neg  = i_real_part[DATA_WIDTH-1];
    assign n_flag_in.im_zero = (i_imag_part == '0);
    assign n_flag_in.im_neg  = i_imag_part[DATA_WIDTH-1];

    t_flags r_flag [ANG_STG+1];
    logic [cpe_pkg::NORM_W-1:0] r_nx  [NORM_N+1];
    logic [cpe_pkg::NORM_W-1:0] r_ny  [NORM_N+1];
    logic [cpe_pkg::NORM_W-1:0] r_nor [NORM_N+1];

    always_ff @(posedge i_clk) begin
        r_flag[0] <= n_flag_in;
        r_nx[0]   <= cpe_pkg::NORM_W'(re_mag);
        r_ny[0]   <= cpe_pkg::NORM_W'(im_mag);
        r_nor[0]  <= cpe_pkg::NORM_W'(re_mag | im_mag);
        for (int j = 1; j <= ANG_STG; j++) begin
            r_flag[j] <= r_flag[j-1];
        end
    end

    // ---------------- normalize: shift by 32,16,8,4,2,1 ----------------
    // max(x,y) < 2^k is the same test as (x|y) < 2^k
    for (genvar k = 0; k < NORM_N; k++) begin : g_norm
        localparam int SH_K = 32 >> k;
        logic do_shift;
        assign do_shift = ((r_nor[k] >> (cpe_pkg::NORM_W - SH_K)) == '0);
        always_ff @(posedge i_clk) begin
            r_nx[k+1]  <= do_shift ? (r_nx[k] << SH_K)  : r_nx[k];
            r_ny[k+1]  <= do_shift ? (r_ny[k] << SH_K)  : r_ny[k];
            r_nor[k+1] <= do_shift ? (r_nor[k] << SH_K) : r_nor[k];
        end
    end

    // ---------------- vectoring CORDIC ----------------
    logic signed [cpe_pkg::VEC_W-1:0]  r_vx [NSTEPS];
    logic signed [cpe_pkg::VEC_W-1:0]  r_vy [NSTEPS];
    logic signed [cpe_pkg::VECZ_W-1:0] r_vz [NSTEPS];

    for (genvar i = 0; i < NSTEPS; i++) begin : g_vec
        logic signed [cpe_pkg::VEC_W-1:0]  vx_in, vy_in;
        logic signed [cpe_pkg::VECZ_W-1:0] vz_in, atan_i;
        logic                              y_pos;
        if (i == 0) begin : g_first
            assign vx_in = $signed({{(cpe_pkg::VEC_W - cpe_pkg::NORM_W){1'b0}}, r_nx[NORM_N]});
            assign vy_in = $signed({{(cpe_pkg::VEC_W - cpe_pkg::NORM_W){1'b0}}, r_ny[NORM_N]});
            assign vz_in = '0;
        end else begin : g_next
            assign vx_in = r_vx[i-1];
            assign vy_in = r_vy[i-1];
            assign vz_in = r_vz[i-1];
        end
        assign atan_i = $signed({{(cpe_pkg::VECZ_W - 32){1'b0}}, cpe_pkg::ATAN_TURNS[i]});
        assign y_pos  = !vy_in[cpe_pkg::VEC_W-1] && (vy_in != '0);
        always_ff @(posedge i_clk) begin
            r_vx[i] <= y_pos ? vx_in + (vy_in >>> i) : vx_in - (vy_in >>> i);
            r_vy[i] <= y_pos ? vy_in - (vx_in >>> i) : vy_in + (vx_in >>> i);
            r_vz[i] <= y_pos ? vz_in + atan_i : vz_in - atan_i;
        end
    end

    // ---------------- quadrant stage ----------------
    logic [32:0] ang_a, n_ang33;
    logic [31:0] r_ang;
    t_flags      qf;

    assign qf = r_flag[ANG_STG-1];

    always_comb begin
        // clamp to [0, quarter turn]
        if (r_vz[NSTEPS-1][cpe_pkg::VECZ_W-1]) begin
            ang_a = '0;
        end else if (r_vz[NSTEPS-1] > $signed({1'b0, cpe_pkg::QUARTER_TURN})) begin
            ang_a = cpe_pkg::QUARTER_TURN;
        end else begin
            ang_a = r_vz[NSTEPS-1][32:0];
        end

        if (qf.re_zero) begin
            if (qf.im_zero)     n_ang33 = '0;
            else if (qf.im_neg) n_ang33 = cpe_pkg::THREE_QUARTER_TURN;
            else                n_ang33 = cpe_pkg::QUARTER_TURN;
        end else if (!qf.re_neg && !qf.im_neg) begin
            n_ang33 = ang_a;
        end else if (qf.re_neg && !qf.im_neg) begin
            n_ang33 = cpe_pkg::HALF_TURN - ang_a;
        end else if (qf.re_neg) begin
            n_ang33 = cpe_pkg::HALF_TURN + ang_a;
        end else begin
            n_ang33 = cpe_pkg::FULL_TURN - ang_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ang <= n_ang33[31:0];
    end

    // rounded half up, wraps modulo one turn
    logic [32:0] phase_sum;
    assign phase_sum = {1'b0, r_ang} + (33'd1 << (31 - PHASE_WIDTH));

    // ---------------- rotation CORDIC ----------------
    logic signed [cpe_pkg::ROT_W-1:0]  r_rx [NSTEPS];
    logic signed [cpe_pkg::ROT_W-1:0]  r_ry [NSTEPS];
    logic signed [cpe_pkg::ROTZ_W-1:0] r_rz [NSTEPS];
    logic [PHASE_WIDTH-1:0]            r_rph [NSTEPS];
    logic [1:0]                        r_rq  [NSTEPS];

    for (genvar i = 0; i < NSTEPS; i++) begin : g_rot
        logic signed [cpe_pkg::ROT_W-1:0]  rx_in, ry_in;
        logic signed [cpe_pkg::ROTZ_W-1:0] rz_in, atan_i;
        logic [PHASE_WIDTH-1:0]            ph_in;
        logic [1:0]                        q_in;
        logic                              z_nonneg;
        if (i == 0) begin : g_first
            assign rx_in = cpe_pkg::INV_GAIN;
            assign ry_in = '0;
            assign rz_in = $signed({3'b000, r_ang[29:0]});
            assign ph_in = phase_sum[31 -: PHASE_WIDTH];
            assign q_in  = r_ang[31:30];
        end else begin : g_next
            assign rx_in = r_rx[i-1];
            assign ry_in = r_ry[i-1];
            assign rz_in = r_rz[i-1];
            assign ph_in = r_rph[i-1];
            assign q_in  = r_rq[i-1];
        end
        assign atan_i   = $signed({{(cpe_pkg::ROTZ_W - 32){1'b0}}, cpe_pkg::ATAN_TURNS[i]});
        assign z_nonneg = !rz_in[cpe_pkg::ROTZ_W-1];
        always_ff @(posedge i_clk) begin
            r_rx[i]  <= z_nonneg ? rx_in - (ry_in >>> i) : rx_in + (ry_in >>> i);
            r_ry[i]  <= z_nonneg ? ry_in + (rx_in >>> i) : ry_in - (rx_in >>> i);
            r_rz[i]  <= z_nonneg ? rz_in - atan_i : rz_in + atan_i;
            r_rph[i] <= ph_in;
            r_rq[i]  <= q_in;
        end
    end

    // ---------------- quadrant map ----------------
    logic signed [cpe_pkg::ROT_W-1:0] c_end, s_end, n_mc, n_ms;
    logic signed [cpe_pkg::ROT_W-1:0] r_mc, r_ms;
    logic [PHASE_WIDTH-1:0]           r_mph;

    assign c_end = r_rx[NSTEPS-1];
    assign s_end = r_ry[NSTEPS-1];

    always_comb begin
        case (r_rq[NSTEPS-1])
            2'd0:    begin n_mc = c_end;  n_ms = s_end;  end
            2'd1:    begin n_mc = -s_end; n_ms = c_end;  end
            2'd2:    begin n_mc = -c_end; n_ms = -s_end; end
            default: begin n_mc = s_end;  n_ms = -c_end; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mc  <= n_mc;
        r_ms  <= n_ms;
        r_mph <= r_rph[NSTEPS-1];
    end

    // ---------------- round half up and saturate ----------------
    logic signed [33:0] cos_r, sin_r, n_cos, n_sin;

    assign cos_r = ($signed({r_mc[cpe_pkg::ROT_W-1], r_mc}) + TRIG_RND) >>> TRIG_SH;
    assign sin_r = ($signed({r_ms[cpe_pkg::ROT_W-1], r_ms}) + TRIG_RND) >>> TRIG_SH;

    always_comb begin
        if (cos_r > TRIG_MAX)      n_cos = TRIG_MAX;
        else if (cos_r < TRIG_MIN) n_cos = TRIG_MIN;
        else                       n_cos = cos_r;
        if (sin_r > TRIG_MAX)      n_sin = TRIG_MAX;
        else if (sin_r < TRIG_MIN) n_sin = TRIG_MIN;
        else                       n_sin = sin_r;
    end

    logic [PHASE_WIDTH-1:0]        r_phase;
    logic signed [TRIG_WIDTH-1:0]  r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        r_phase <= r_mph;
        r_cos   <= n_cos[TRIG_WIDTH-1:0];
        r_sin   <= n_sin[TRIG_WIDTH-1:0];
    end

    assign o_phase_turns = r_phase;
    assign o_cos_value   = r_cos;
    assign o_sin_value   = r_sin;

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##STAGES o_valid)
        else $error("result strobe missing after fixed latency");

    a_norm_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NORM_N] && !r_flag[NORM_N].re_zero) |-> r_nor[NORM_N][cpe_pkg::NORM_W-1])
        else $error("normalizer left magnitude below target range");

    a_first_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ANG_STG] && !r_flag[ANG_STG].re_neg && !r_flag[ANG_STG].im_neg)
            |-> ({1'b0, r_ang} <= cpe_pkg::QUARTER_TURN))
        else $error("first quadrant angle beyond quarter turn");

    a_axis_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ANG_STG] && r_flag[ANG_STG].re_zero) |-> (r_ang[29:0] == '0))
        else $error("zero real part not on an axis angle");

endmodule
